// ===== hw/rtl/srev_pkg.sv =====
// srev_pkg: types, register map, reset values and fixed-point helpers
// of the reverb block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package srev_pkg;

    localparam int SampleW = 16;
    localparam int AccW    = 24;
    localparam int GainW   = 16;
    localparam int ProdW   = AccW + GainW + 1;
    localparam int AddrW   = 5;
    localparam int NumLine = 6;

    typedef logic signed [SampleW-1:0] sample_t;
    typedef logic signed [AccW-1:0]    acc_t;
    typedef logic signed [AccW:0]      rnd_t;
    typedef logic signed [ProdW-1:0]   prod_t;
    typedef logic        [GainW-1:0]   gain_t;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_COMB_GAIN_1  = 3'd0;
    localparam logic [2:0] REG_COMB_GAIN_2  = 3'd1;
    localparam logic [2:0] REG_COMB_GAIN_3  = 3'd2;
    localparam logic [2:0] REG_COMB_GAIN_4  = 3'd3;
    localparam logic [2:0] REG_ALLPASS_GAIN = 3'd4;
    localparam logic [2:0] REG_WET_LEVEL    = 3'd5;

    localparam gain_t RST_COMB_GAIN_1  = 16'd53288;
    localparam gain_t RST_COMB_GAIN_2  = 16'd51466;
    localparam gain_t RST_COMB_GAIN_3  = 16'd49755;
    localparam gain_t RST_COMB_GAIN_4  = 16'd48006;
    localparam gain_t RST_ALLPASS_GAIN = 16'd45875;
    localparam gain_t RST_WET_LEVEL    = 16'd39322;

    localparam acc_t    ACC_MAX    = 24'sh7FFFFF;
    localparam acc_t    ACC_MIN    = -24'sh800000;
    localparam sample_t SAMPLE_MAX = 16'sh7FFF;
    localparam sample_t SAMPLE_MIN = -16'sh8000;

    // exact signed value times unsigned Q0.16 gain
    function automatic prod_t mul_q16(input acc_t v, input gain_t g);
        prod_t a;
        prod_t b;
        a = prod_t'(v);
        b = prod_t'({1'b0, g});
        return a * b;
    endfunction

    // drop 16 fraction bits, half rounds toward +infinity
    function automatic rnd_t rnd_q16(input prod_t p);
        logic signed [ProdW:0] t;
        t = (ProdW+1)'(p) + (ProdW+1)'(32768);
        return t[ProdW-1:16];
    endfunction

    function automatic acc_t sat24(input logic signed [AccW+1:0] v);
        if (v[AccW+1:AccW-1] == 3'b000 || v[AccW+1:AccW-1] == 3'b111)
            return v[AccW-1:0];
        else if (v[AccW+1])
            return ACC_MIN;
        else
            return ACC_MAX;
    endfunction

    function automatic sample_t sat16(input logic signed [AccW+1:0] v);
        if (v[AccW+1:SampleW-1] == '0 || v[AccW+1:SampleW-1] == '1)
            return v[SampleW-1:0];
        else if (v[AccW+1])
            return SAMPLE_MIN;
        else
            return SAMPLE_MAX;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/srev_ram.sv =====
// srev_ram: generic simple dual-port RAM, one write and one registered read
// port, write-first on an address collision. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module srev_ram #(
    parameter  int Width = 24,
    parameter  int Depth = 16,
    localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
    input  wire logic                  clk,
    input  wire logic                  we,
    input  wire logic [AddrW-1:0]      waddr,
    input  wire logic [Width-1:0]      wdata,
    input  wire logic [AddrW-1:0]      raddr,
    output logic      [Width-1:0]      rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (we && (waddr == raddr))
        begin
            rdata <= wdata;
        end
        else
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/schroeder_reverb.sv =====
// schroeder_reverb: four feedback combs, two allpass sections, dry/wet mix.
// Depends on srev_pkg and srev_ram.
//
//   port group   direction  role
//   s_axis_*     in         dry sample items
//   m_axis_*     out        reverberated sample items
//   p*           in/out     APB register access
//
// An item is never accepted right after another one; each delay line RAM takes
// one read and one write per item, which sets that limit. m_axis_tvalid rises
// once an accepted item has passed the free-running pipeline into the queue.
// After reset a clearing pass zeroes every word of the delay lines, the longest
// line setting its length; no item is accepted meanwhile.
// A 16-entry output queue with credit counting absorbs m_axis_tready stalls.
`timescale 1ns / 1ps
`default_nettype none

module schroeder_reverb #(
    parameter int COMB_DELAY_1    = 1321,
    parameter int COMB_DELAY_2    = 1543,
    parameter int COMB_DELAY_3    = 1759,
    parameter int COMB_DELAY_4    = 1987,
    parameter int ALLPASS_DELAY_1 = 223,
    parameter int ALLPASS_DELAY_2 = 73
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [srev_pkg::AddrW-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [15:0]                 s_axis_tdata,   // [15:0] sample_in
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic      [15:0]                 m_axis_tdata    // [15:0] sample_out
);

    localparam int LineAp1 = 4;
    localparam int LineAp2 = 5;
    localparam int NumLine = srev_pkg::NumLine;
    localparam int LineDepth [NumLine] = '{COMB_DELAY_1, COMB_DELAY_2, COMB_DELAY_3,
                                           COMB_DELAY_4, ALLPASS_DELAY_1, ALLPASS_DELAY_2};
    localparam int Max01    = (COMB_DELAY_1 > COMB_DELAY_2) ? COMB_DELAY_1 : COMB_DELAY_2;
    localparam int Max23    = (COMB_DELAY_3 > COMB_DELAY_4) ? COMB_DELAY_3 : COMB_DELAY_4;
    localparam int Max45    = (ALLPASS_DELAY_1 > ALLPASS_DELAY_2) ? ALLPASS_DELAY_1
                                                                  : ALLPASS_DELAY_2;
    localparam int Max03    = (Max01 > Max23) ? Max01 : Max23;
    localparam int MaxDepth = (Max03 > Max45) ? Max03 : Max45;
    localparam int ClrW     = $clog2(MaxDepth + 1);
    localparam int NumStage = 14;
    localparam int QDepth   = 16;
    localparam int QAddrW   = $clog2(QDepth);

    // ---------------- configuration registers ----------------
    srev_pkg::gain_t comb_gain_reg [4];
    srev_pkg::gain_t allpass_gain_reg;
    srev_pkg::gain_t wet_level_reg;
    logic            cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comb_gain_reg[0] <= srev_pkg::RST_COMB_GAIN_1;
            comb_gain_reg[1] <= srev_pkg::RST_COMB_GAIN_2;
            comb_gain_reg[2] <= srev_pkg::RST_COMB_GAIN_3;
            comb_gain_reg[3] <= srev_pkg::RST_COMB_GAIN_4;
            allpass_gain_reg <= srev_pkg::RST_ALLPASS_GAIN;
            wet_level_reg    <= srev_pkg::RST_WET_LEVEL;
        end
        else if (cfg_we)
        begin
            unique case (paddr[4:2])
                srev_pkg::REG_COMB_GAIN_1:  comb_gain_reg[0] <= pwdata[15:0];
                srev_pkg::REG_COMB_GAIN_2:  comb_gain_reg[1] <= pwdata[15:0];
                srev_pkg::REG_COMB_GAIN_3:  comb_gain_reg[2] <= pwdata[15:0];
                srev_pkg::REG_COMB_GAIN_4:  comb_gain_reg[3] <= pwdata[15:0];
                srev_pkg::REG_ALLPASS_GAIN: allpass_gain_reg <= pwdata[15:0];
                srev_pkg::REG_WET_LEVEL:    wet_level_reg    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            srev_pkg::REG_COMB_GAIN_1:  prdata = {16'd0, comb_gain_reg[0]};
            srev_pkg::REG_COMB_GAIN_2:  prdata = {16'd0, comb_gain_reg[1]};
            srev_pkg::REG_COMB_GAIN_3:  prdata = {16'd0, comb_gain_reg[2]};
            srev_pkg::REG_COMB_GAIN_4:  prdata = {16'd0, comb_gain_reg[3]};
            srev_pkg::REG_ALLPASS_GAIN: prdata = {16'd0, allpass_gain_reg};
            srev_pkg::REG_WET_LEVEL:    prdata = {16'd0, wet_level_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    // ---------------- clearing pass ----------------
    logic [ClrW-1:0] clr_cnt_reg;
    logic            clr_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clr_done_reg <= 1'b0;
        end
        else if (!clr_done_reg)
        begin
            if (clr_cnt_reg == ClrW'(MaxDepth - 1))
            begin
                clr_done_reg <= 1'b1;
            end
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // ---------------- input handshake and credits ----------------
    logic [NumStage:1]   vld_reg;
    srev_pkg::sample_t   x_pipe_reg [1:NumStage];
    logic [QAddrW:0]     credit_reg;
    logic                in_fire;
    logic                out_fire;

    // vld_reg[1] marks the cycle right after an accept: no item is accepted in it
    assign s_axis_tready = clr_done_reg && !vld_reg[1] && (credit_reg < (QAddrW+1)'(QDepth));
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            credit_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[NumStage-1:1], in_fire};
            if (in_fire && !out_fire)
            begin
                credit_reg <= credit_reg + 1'b1;
            end
            else if (!in_fire && out_fire)
            begin
                credit_reg <= credit_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_pipe_reg[1] <= s_axis_tdata;
        for (int i = 2; i <= NumStage; i++)
        begin
            x_pipe_reg[i] <= x_pipe_reg[i-1];
        end
    end

    // ---------------- delay line memories ----------------
    logic [srev_pkg::AccW-1:0] line_rdata [NumLine];
    srev_pkg::acc_t            line_wdata [NumLine];
    logic [NumLine-1:0]        line_rd_go;
    logic [NumLine-1:0]        line_wr_go;

    assign line_rd_go = {vld_reg[8], vld_reg[4], {4{in_fire}}};
    assign line_wr_go = {vld_reg[10], vld_reg[6], {4{vld_reg[2]}}};

    for (genvar g = 0; g < NumLine; g++)
    begin : g_line
        localparam int D  = LineDepth[g];
        localparam int AW = (D > 1) ? $clog2(D) : 1;

        logic [AW-1:0]             rd_ptr_reg;
        logic [AW-1:0]             wr_ptr_reg;
        logic [AW-1:0]             ram_waddr;
        logic                      ram_we;
        logic [srev_pkg::AccW-1:0] ram_wdata;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                rd_ptr_reg <= '0;
                wr_ptr_reg <= '0;
            end
            else
            begin
                if (line_rd_go[g])
                begin
                    rd_ptr_reg <= (rd_ptr_reg == AW'(D - 1)) ? '0 : rd_ptr_reg + 1'b1;
                end
                if (line_wr_go[g])
                begin
                    wr_ptr_reg <= (wr_ptr_reg == AW'(D - 1)) ? '0 : wr_ptr_reg + 1'b1;
                end
            end
        end

        always_comb
        begin
            if (!clr_done_reg)
            begin
                ram_we    = (32'(clr_cnt_reg) < D);
                ram_waddr = clr_cnt_reg[AW-1:0];
                ram_wdata = '0;
            end
            else
            begin
                ram_we    = line_wr_go[g];
                ram_waddr = wr_ptr_reg;
                ram_wdata = line_wdata[g];
            end
        end

        srev_ram #(
            .Width (srev_pkg::AccW),
            .Depth (D)
        ) u_ram (
            .clk   (clk),
            .we    (ram_we),
            .waddr (ram_waddr),
            .wdata (ram_wdata),
            .raddr (rd_ptr_reg),
            .rdata (line_rdata[g])
        );
    end

    // ---------------- datapath ----------------
    srev_pkg::prod_t p2_prod_reg [4];
    srev_pkg::acc_t  p3_c_reg [4];
    srev_pkg::acc_t  p4_s12_reg, p4_c3_reg, p4_c4_reg;
    srev_pkg::acc_t  p5_sum_reg;
    srev_pkg::prod_t p6_prod_reg;
    srev_pkg::acc_t  p6_v_reg, p6_old_reg;
    srev_pkg::acc_t  p7_w_reg, p7_old_reg;
    srev_pkg::prod_t p8_prod_reg;
    srev_pkg::acc_t  p8_old_reg;
    srev_pkg::acc_t  p9_v_reg;
    srev_pkg::prod_t p10_prod_reg;
    srev_pkg::acc_t  p10_v_reg, p10_old_reg;
    srev_pkg::acc_t  p11_w_reg, p11_old_reg;
    srev_pkg::prod_t p12_prod_reg;
    srev_pkg::acc_t  p12_old_reg;
    srev_pkg::acc_t  p13_y_reg;
    srev_pkg::prod_t p14_prod_reg;

    srev_pkg::acc_t    comb_c [4];
    srev_pkg::acc_t    sum_a;
    srev_pkg::acc_t    ap1_w, ap2_w;
    srev_pkg::sample_t out_sample;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            comb_c[k] = srev_pkg::sat24(26'(x_pipe_reg[2])
                                        + 26'(srev_pkg::rnd_q16(p2_prod_reg[k])));
            line_wdata[k] = comb_c[k];
        end
        sum_a = srev_pkg::sat24(26'(p4_s12_reg) + 26'(p4_c3_reg));
        ap1_w = srev_pkg::sat24(26'(p6_v_reg) + 26'(srev_pkg::rnd_q16(p6_prod_reg)));
        ap2_w = srev_pkg::sat24(26'(p10_v_reg) + 26'(srev_pkg::rnd_q16(p10_prod_reg)));
        line_wdata[LineAp1] = ap1_w;
        line_wdata[LineAp2] = ap2_w;
        out_sample = srev_pkg::sat16(26'(x_pipe_reg[NumStage])
                                     + 26'(srev_pkg::rnd_q16(p14_prod_reg)));
    end

    always_ff @(posedge clk)
    begin
        // combs: read data arrives in the cycle after the accept
        for (int k = 0; k < 4; k++)
        begin
            p2_prod_reg[k] <= srev_pkg::mul_q16(line_rdata[k], comb_gain_reg[k]);
            p3_c_reg[k]    <= comb_c[k];
        end
        p4_s12_reg <= srev_pkg::sat24(26'(p3_c_reg[0]) + 26'(p3_c_reg[1]));
        p4_c3_reg  <= p3_c_reg[2];
        p4_c4_reg  <= p3_c_reg[3];
        p5_sum_reg <= srev_pkg::sat24(26'(sum_a) + 26'(p4_c4_reg));

        // first allpass: w = v + g*old, y = old - g*w
        p6_prod_reg <= srev_pkg::mul_q16(line_rdata[LineAp1], allpass_gain_reg);
        p6_v_reg    <= p5_sum_reg;
        p6_old_reg  <= line_rdata[LineAp1];
        p7_w_reg    <= ap1_w;
        p7_old_reg  <= p6_old_reg;
        p8_prod_reg <= srev_pkg::mul_q16(p7_w_reg, allpass_gain_reg);
        p8_old_reg  <= p7_old_reg;
        p9_v_reg    <= srev_pkg::sat24(26'(p8_old_reg) - 26'(srev_pkg::rnd_q16(p8_prod_reg)));

        // second allpass
        p10_prod_reg <= srev_pkg::mul_q16(line_rdata[LineAp2], allpass_gain_reg);
        p10_v_reg    <= p9_v_reg;
        p10_old_reg  <= line_rdata[LineAp2];
        p11_w_reg    <= ap2_w;
        p11_old_reg  <= p10_old_reg;
        p12_prod_reg <= srev_pkg::mul_q16(p11_w_reg, allpass_gain_reg);
        p12_old_reg  <= p11_old_reg;
        p13_y_reg    <= srev_pkg::sat24(26'(p12_old_reg)
                                        - 26'(srev_pkg::rnd_q16(p12_prod_reg)));

        // wet mix
        p14_prod_reg <= srev_pkg::mul_q16(p13_y_reg, wet_level_reg);
    end

    // ---------------- output queue ----------------
    srev_pkg::sample_t q_mem [QDepth];
    logic [QAddrW-1:0] q_wr_ptr_reg;
    logic [QAddrW-1:0] q_rd_ptr_reg;
    logic [QAddrW:0]   q_cnt_reg;
    logic              q_push;

    assign q_push        = vld_reg[NumStage];
    assign m_axis_tvalid = (q_cnt_reg != '0);
    assign m_axis_tdata  = q_mem[q_rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            q_mem[q_wr_ptr_reg] <= out_sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_ptr_reg <= '0;
            q_rd_ptr_reg <= '0;
            q_cnt_reg    <= '0;
        end
        else
        begin
            if (q_push)
            begin
                q_wr_ptr_reg <= q_wr_ptr_reg + 1'b1;
            end
            if (out_fire)
            begin
                q_rd_ptr_reg <= q_rd_ptr_reg + 1'b1;
            end
            if (q_push && !out_fire)
            begin
                q_cnt_reg <= q_cnt_reg + 1'b1;
            end
            else if (!q_push && out_fire)
            begin
                q_cnt_reg <= q_cnt_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire
